### rtl/tfn_pkg.sv
package tfn_pkg;

    localparam int COORD_W  = 16;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * EDGE_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int POS_W    = 6;
    localparam int NORM_W   = 31;
    localparam int NORM_TOP = NORM_W - 1;
    localparam int SQ_W     = 2 * NORM_W;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int FRAC_W   = 14;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int DREM_W   = NORM_W + FRAC_W + 2;
    localparam int OUT_W    = 16;

    localparam int CROSS_LAT = 4;
    localparam int NORM_LAT  = 4;
    localparam int ISQRT_LAT = ROOT_W;
    localparam int DIV_LAT   = QUO_W;
    localparam int LATENCY   = CROSS_LAT + NORM_LAT + ISQRT_LAT + DIV_LAT + 1;

    localparam logic signed [OUT_W-1:0] ONE_Q14 = OUT_W'(1 << FRAC_W);

    typedef struct packed {
        logic [2:0][NORM_W-1:0] u;
        logic [2:0]             neg;
        logic                   degen;
    } t_side;

endpackage

### rtl/tfn_cross.sv
module tfn_cross (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [2:0][tfn_pkg::COORD_W-1:0]     i_a,
    input  logic [2:0][tfn_pkg::COORD_W-1:0]     i_b,
    input  logic [2:0][tfn_pkg::COORD_W-1:0]     i_c,
    output logic                                 o_valid,
    output logic [2:0][tfn_pkg::CROSS_W-1:0]     o_u,
    output logic [2:0]                           o_neg,
    output logic [tfn_pkg::CROSS_W-1:0]          o_max,
    output logic                                 o_degen
);
    import tfn_pkg::*;

    logic [3:0]                  r_v;
    logic [2:0][EDGE_W-1:0]      r_e1, r_e2;
    logic [2:0][PROD_W-1:0]      r_p, r_q;
    logic [2:0][CROSS_W-1:0]     r_n;
    logic [2:0][CROSS_W-1:0]     r_u;
    logic [2:0]                  r_neg;
    logic [CROSS_W-1:0]          r_max;
    logic                        r_degen;

    logic [2:0][CROSS_W-1:0]     n_u;
    logic [2:0]                  n_neg;
    logic [CROSS_W-1:0]          n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = r_n[i][CROSS_W-1];
            n_u[i]   = n_neg[i] ? CROSS_W'(-r_n[i]) : r_n[i];
        end
        n_max = n_u[0];
        if (n_u[1] > n_max) n_max = n_u[1];
        if (n_u[2] > n_max) n_max = n_u[2];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= {i_b[i][COORD_W-1], i_b[i]} - {i_a[i][COORD_W-1], i_a[i]};
            r_e2[i] <= {i_c[i][COORD_W-1], i_c[i]} - {i_a[i][COORD_W-1], i_a[i]};
        end
        r_p[0] <= PROD_W'($signed(r_e1[1]) * $signed(r_e2[2]));
        r_q[0] <= PROD_W'($signed(r_e1[2]) * $signed(r_e2[1]));
        r_p[1] <= PROD_W'($signed(r_e1[2]) * $signed(r_e2[0]));
        r_q[1] <= PROD_W'($signed(r_e1[0]) * $signed(r_e2[2]));
        r_p[2] <= PROD_W'($signed(r_e1[0]) * $signed(r_e2[1]));
        r_q[2] <= PROD_W'($signed(r_e1[1]) * $signed(r_e2[0]));
        for (int i = 0; i < 3; i++) begin
            r_n[i] <= {r_p[i][PROD_W-1], r_p[i]} - {r_q[i][PROD_W-1], r_q[i]};
        end
        r_u     <= n_u;
        r_neg   <= n_neg;
        r_max   <= n_max;
        r_degen <= (n_max == '0);
    end

    assign o_valid = r_v[3];
    assign o_u     = r_u;
    assign o_neg   = r_neg;
    assign o_max   = r_max;
    assign o_degen = r_degen;

endmodule

### rtl/tfn_norm.sv
module tfn_norm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [2:0][tfn_pkg::CROSS_W-1:0]     i_u,
    input  logic [2:0]                           i_neg,
    input  logic [tfn_pkg::CROSS_W-1:0]          i_max,
    input  logic                                 i_degen,
    output logic                                 o_valid,
    output logic [tfn_pkg::SUM_W-1:0]            o_sum,
    output tfn_pkg::t_side                       o_side
);
    import tfn_pkg::*;

    logic [3:0]                  r_v;
    logic [POS_W-1:0]            r_pos;
    logic [2:0][CROSS_W-1:0]     r_u5;
    logic [2:0]                  r_neg5;
    logic                        r_degen5;
    t_side                       r_side6, r_side7, r_side8;
    logic [2:0][SQ_W-1:0]        r_sq;
    logic [SUM_W-1:0]            r_sum;

    logic [POS_W-1:0]            n_pos;
    t_side                       n_side6;
    logic [CROSS_W-1:0]          w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // position of the leading one of the largest magnitude
    always_comb begin
        n_pos = '0;
        for (int i = 0; i < CROSS_W; i++) begin
            if (i_max[i]) n_pos = POS_W'(i);
        end
    end

    // common shift puts the largest magnitude into [2^30, 2^31)
    always_comb begin
        n_side6.neg   = r_neg5;
        n_side6.degen = r_degen5;
        for (int i = 0; i < 3; i++) begin
            if (r_pos > POS_W'(NORM_TOP)) begin
                w_sh = r_u5[i] >> (r_pos - POS_W'(NORM_TOP));
            end else begin
                w_sh = r_u5[i] << (POS_W'(NORM_TOP) - r_pos);
            end
            n_side6.u[i] = w_sh[NORM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_u5     <= i_u;
        r_neg5   <= i_neg;
        r_degen5 <= i_degen;
        r_side6  <= n_side6;
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= SQ_W'(r_side6.u[i]) * SQ_W'(r_side6.u[i]);
        end
        r_side7  <= r_side6;
        r_sum    <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        r_side8  <= r_side7;
    end

    assign o_valid = r_v[3];
    assign o_sum   = r_sum;
    assign o_side  = r_side8;

endmodule

### rtl/tfn_isqrt.sv
module tfn_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tfn_pkg::SUM_W-1:0]     i_sum,
    input  tfn_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [tfn_pkg::ROOT_W-1:0]    o_root,
    output tfn_pkg::t_side                o_side
);
    import tfn_pkg::*;

    logic [ROOT_W-1:0]   r_v;
    logic [REM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [SUM_W-1:0]    r_s    [ROOT_W];
    t_side               r_side [ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    // one root bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_i, rem_n, trial;
        logic [ROOT_W-1:0] root_i;
        logic [SUM_W-1:0]  s_i;
        t_side             side_i;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign s_i    = i_sum;
            assign side_i = i_side;
        end else begin : g_next
            assign rem_i  = r_rem[k-1];
            assign root_i = r_root[k-1];
            assign s_i    = r_s[k-1];
            assign side_i = r_side[k-1];
        end

        assign rem_n = {rem_i[REM_W-3:0], s_i[SUM_W-1 -: 2]};
        assign trial = REM_W'({root_i, 2'b01});

        always_ff @(posedge i_clk) begin
            if (rem_n >= trial) begin
                r_rem[k]  <= rem_n - trial;
                r_root[k] <= {root_i[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_n;
                r_root[k] <= {root_i[ROOT_W-2:0], 1'b0};
            end
            r_s[k]    <= s_i << 2;
            r_side[k] <= side_i;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

### rtl/tfn_div.sv
module tfn_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [tfn_pkg::ROOT_W-1:0]         i_len,
    input  tfn_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic [2:0][tfn_pkg::QUO_W-1:0]     o_quo,
    output logic [2:0]                         o_neg,
    output logic                               o_degen
);
    import tfn_pkg::*;

    logic [QUO_W-1:0]              r_v;
    logic [2:0][DREM_W-1:0]        r_rem   [QUO_W];
    logic [2:0][QUO_W-1:0]         r_q     [QUO_W];
    logic [ROOT_W-1:0]             r_len   [QUO_W];
    logic [2:0]                    r_neg   [QUO_W];
    logic                          r_degen [QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QUO_W-2:0], i_valid};
        end
    end

    // restoring division, quotient bits from the top
    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic [2:0][DREM_W-1:0] rem_i;
        logic [2:0][QUO_W-1:0]  q_i;
        logic [ROOT_W-1:0]      len_i;
        logic [2:0]             neg_i;
        logic                   degen_i;
        logic [DREM_W-1:0]      dv;

        if (k == 0) begin : g_first
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_i[l] = (DREM_W'(i_side.u[l]) << FRAC_W)
                                + DREM_W'(i_len >> 1);
            end
            assign q_i     = '0;
            assign len_i   = i_len;
            assign neg_i   = i_side.neg;
            assign degen_i = i_side.degen;
        end else begin : g_next
            assign rem_i   = r_rem[k-1];
            assign q_i     = r_q[k-1];
            assign len_i   = r_len[k-1];
            assign neg_i   = r_neg[k-1];
            assign degen_i = r_degen[k-1];
        end

        assign dv = DREM_W'(len_i) << BIT;

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 3; l++) begin
                if (rem_i[l] >= dv) begin
                    r_rem[k][l] <= rem_i[l] - dv;
                    r_q[k][l]   <= q_i[l] | QUO_W'(1 << BIT);
                end else begin
                    r_rem[k][l] <= rem_i[l];
                    r_q[k][l]   <= q_i[l];
                end
            end
            r_len[k]   <= len_i;
            r_neg[k]   <= neg_i;
            r_degen[k] <= degen_i;
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_q[QUO_W-1];
    assign o_neg   = r_neg[QUO_W-1];
    assign o_degen = r_degen[QUO_W-1];

endmodule

### rtl/triangle_face_normal_unit.sv
// Triangle flat face normal, one triangle per clock.
// Input: raise start with the nine vertex coordinates (A, B, C; signed Q8.8)
// for one cycle per triangle; the item is taken when start is high and busy
// is low. busy is always low, so a triangle can be presented every cycle.
// Output: o_valid pulses for one cycle with the unit normal in signed Q1.14
// on o_norm_x/y/z and o_degenerate. A zero cross product (collinear or
// coincident vertices) gives a zero normal with o_degenerate set.
// Path: cross product, normalise, square root, divide, then the output register.
// Throughput: one item per cycle; the 32-stage square root pipeline and the
// 15-stage divider pipeline dominate the latency, not the rate.
// Results come out in input order. The receiver cannot stall; each result
// is on the ports for exactly one cycle.
// Reset (synchronous, active low) clears all valid bits; items in flight are
// dropped and no result comes out until new items pass through.
module triangle_face_normal_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_a_x,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_a_y,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_a_z,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_b_x,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_b_y,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_b_z,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_c_x,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_c_y,
    input  logic signed [tfn_pkg::COORD_W-1:0]  i_c_z,
    output logic                                o_valid,
    output logic signed [tfn_pkg::OUT_W-1:0]    o_norm_x,
    output logic signed [tfn_pkg::OUT_W-1:0]    o_norm_y,
    output logic signed [tfn_pkg::OUT_W-1:0]    o_norm_z,
    output logic                                o_degenerate
);
    import tfn_pkg::*;

    logic                        w_cr_v, w_nm_v, w_sq_v, w_dv_v;
    logic [2:0][CROSS_W-1:0]     w_cr_u;
    logic [2:0]                  w_cr_neg;
    logic [CROSS_W-1:0]          w_cr_max;
    logic                        w_cr_degen;
    logic [SUM_W-1:0]            w_sum;
    t_side                       w_nm_side, w_sq_side;
    logic [ROOT_W-1:0]           w_len;
    logic [2:0][QUO_W-1:0]       w_quo;
    logic [2:0]                  w_dv_neg;
    logic                        w_dv_degen;

    logic                        r_valid;
    logic [2:0][OUT_W-1:0]       r_norm;
    logic                        r_degen;
    logic [2:0][OUT_W-1:0]       n_norm;

    assign busy = 1'b0;

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_a     ({i_a_z, i_a_y, i_a_x}),
        .i_b     ({i_b_z, i_b_y, i_b_x}),
        .i_c     ({i_c_z, i_c_y, i_c_x}),
        .o_valid (w_cr_v),
        .o_u     (w_cr_u),
        .o_neg   (w_cr_neg),
        .o_max   (w_cr_max),
        .o_degen (w_cr_degen)
    );

    tfn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cr_v),
        .i_u     (w_cr_u),
        .i_neg   (w_cr_neg),
        .i_max   (w_cr_max),
        .i_degen (w_cr_degen),
        .o_valid (w_nm_v),
        .o_sum   (w_sum),
        .o_side  (w_nm_side)
    );

    tfn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_nm_v),
        .i_sum   (w_sum),
        .i_side  (w_nm_side),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_v),
        .i_len   (w_len),
        .i_side  (w_sq_side),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_neg   (w_dv_neg),
        .o_degen (w_dv_degen)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_dv_degen) begin
                n_norm[i] = '0;
            end else if (w_dv_neg[i]) begin
                n_norm[i] = OUT_W'(-{1'b0, w_quo[i]});
            end else begin
                n_norm[i] = OUT_W'({1'b0, w_quo[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_norm  <= n_norm;
        r_degen <= w_dv_degen;
    end

    assign o_valid      = r_valid;
    assign o_norm_x     = r_norm[0];
    assign o_norm_y     = r_norm[1];
    assign o_norm_z     = r_norm[2];
    assign o_degenerate = r_degen;

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without an accepted item");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_norm_x == '0 && o_norm_y == '0 && o_norm_z == '0))
        else $error("degenerate item with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate) |->
            (o_norm_x <= ONE_Q14 && o_norm_x >= -ONE_Q14 &&
             o_norm_y <= ONE_Q14 && o_norm_y >= -ONE_Q14 &&
             o_norm_z <= ONE_Q14 && o_norm_z >= -ONE_Q14))
        else $error("normal component out of range");

endmodule
